// ===== hdl/achc_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm qualifier package
// Shared widths, codes and register reset values for the alarm qualifier.
// ----------------------------------------------------------------------------
package achc_pkg;

  // Width of the consecutive danger and clear run counters.
  localparam int unsigned RunWidth  = 8;
  // Width of the tick arithmetic used for hold and cooldown deadlines.
  localparam int unsigned TickWidth = 32;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 31;

  localparam logic [RunWidth-1:0] RunMax = {RunWidth{1'b1}};

  localparam logic [7:0]  ConfirmCountRst  = 8'd2;
  localparam logic [7:0]  ClearCountRst    = 8'd3;
  localparam logic [30:0] HoldTicksRst     = 31'd2000;
  localparam logic [30:0] CooldownTicksRst = 31'd3000;

  localparam logic [7:0] DangerLabel = 8'd1;

  typedef enum logic [2:0] {
    RISK_OFF        = 3'd0,
    RISK_MONITORING = 3'd1,
    RISK_SUSPICIOUS = 3'd2,
    RISK_ALERTING   = 3'd3,
    RISK_COOLDOWN   = 3'd4
  } risk_e;

  typedef enum logic [1:0] {
    CMD_WINDOW = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CONFIRM_COUNT  = 2'd0,
    CFG_CLEAR_COUNT    = 2'd1,
    CFG_HOLD_TICKS     = 2'd2,
    CFG_COOLDOWN_TICKS = 2'd3
  } cfg_idx_e;

endpackage

// ===== hdl/achc_if.sv =====
// ----------------------------------------------------------------------------
// Alarm qualifier channels
// Valid/ready channel interfaces for window items and alarm results.
// ----------------------------------------------------------------------------
interface achc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  class_label;
  logic [15:0] danger_probability;
  logic [31:0] tick_stamp;

  modport source (
    output valid, command, class_label, danger_probability, tick_stamp,
    input  ready
  );
  modport sink (
    input  valid, command, class_label, danger_probability, tick_stamp,
    output ready
  );
endinterface

interface achc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  risk_code;
  logic        alert_raised;
  logic        alert_cleared;
  logic [31:0] alert_number;
  logic        alarm_active;
  logic        stable_danger;
  logic        last_detected_danger;
  logic [15:0] last_alert_confidence;
  logic [15:0] latest_confidence;

  modport source (
    output valid, risk_code, alert_raised, alert_cleared, alert_number, alarm_active,
           stable_danger, last_detected_danger, last_alert_confidence, latest_confidence,
    input  ready
  );
  modport sink (
    input  valid, risk_code, alert_raised, alert_cleared, alert_number, alarm_active,
           stable_danger, last_detected_danger, last_alert_confidence, latest_confidence,
    output ready
  );
endinterface

// ===== hdl/alarm_confirm_hold_cooldown_core.sv =====
// The block takes one command or window transaction per clock cycle while the output is not
// stalled, and returns exactly one result transaction for each, held first in the input
// register and then in the result register. The whole state update (run counters, deadline
// compares and the risk state machine) is combinational between those two registers, which
// sets the sustained rate of one item per cycle.
// ----------------------------------------------------------------------------
// Alarm qualifier core
// Confirms danger windows into an alarm with hold and cooldown deadlines.
// ----------------------------------------------------------------------------
module alarm_confirm_hold_cooldown_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  achc_in_if.sink                           in_if,
  achc_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [achc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [achc_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  localparam int unsigned RW = achc_pkg::RunWidth;
  localparam int unsigned TW = achc_pkg::TickWidth;

  // Configuration registers.
  logic [7:0]  confirm_q;
  logic [7:0]  clear_cnt_q;
  logic [30:0] hold_ticks_q;
  logic [30:0] cool_ticks_q;

  // Input register.
  logic        in_vld_q;
  logic [1:0]  cmd_q;
  logic [7:0]  label_q;
  logic [15:0] prob_q;
  logic [TW-1:0] now_q;

  // Block state.
  logic          running_q, running_d;
  achc_pkg::risk_e risk_q, risk_d;
  logic [RW-1:0] danger_run_q, danger_run_d;
  logic [RW-1:0] clear_run_q, clear_run_d;
  logic [TW-1:0] hold_dl_q, hold_dl_d;
  logic [TW-1:0] cool_dl_q, cool_dl_d;
  logic          overlay_q, overlay_d;
  logic          stable_q, stable_d;
  logic          detected_q, detected_d;
  logic [15:0]   alert_conf_q, alert_conf_d;
  logic [15:0]   win_conf_q, win_conf_d;
  logic [31:0]   alert_cnt_q, alert_cnt_d;
  logic          raised_d, cleared_d;

  // Result register.
  logic            out_vld_q;
  achc_pkg::risk_e res_risk_q;
  logic            res_raised_q;
  logic            res_cleared_q;
  logic [31:0]     res_alert_num_q;
  logic            res_active_q;
  logic            res_stable_q;
  logic            res_detected_q;
  logic [15:0]     res_alert_conf_q;
  logic [15:0]     res_win_conf_q;

  logic advance;

  // A deadline has been reached when the wrap-around difference is non-negative.
  function automatic logic reached(input logic [TW-1:0] now, input logic [TW-1:0] deadline);
    logic [TW-1:0] diff;
    diff = now - deadline;
    return ~diff[TW-1];
  endfunction

  assign advance      = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready  = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q    <= achc_pkg::ConfirmCountRst;
      clear_cnt_q  <= achc_pkg::ClearCountRst;
      hold_ticks_q <= achc_pkg::HoldTicksRst;
      cool_ticks_q <= achc_pkg::CooldownTicksRst;
    end else if (cfg_we_i) begin
      unique case (achc_pkg::cfg_idx_e'(cfg_idx_i))
        achc_pkg::CFG_CONFIRM_COUNT:  confirm_q    <= cfg_wdata_i[7:0];
        achc_pkg::CFG_CLEAR_COUNT:    clear_cnt_q  <= cfg_wdata_i[7:0];
        achc_pkg::CFG_HOLD_TICKS:     hold_ticks_q <= cfg_wdata_i;
        achc_pkg::CFG_COOLDOWN_TICKS: cool_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      cmd_q   <= in_if.command;
      label_q <= in_if.class_label;
      prob_q  <= in_if.danger_probability;
      now_q   <= in_if.tick_stamp[TW-1:0];
    end
  end

  always_comb begin
    logic          danger;
    logic          in_cool;
    logic [RW-1:0] danger_inc;
    logic [RW-1:0] clear_inc;
    logic [31:0]   hold_sum;
    logic [31:0]   cool_sum;

    danger     = (label_q == achc_pkg::DangerLabel);
    in_cool    = (risk_q == achc_pkg::RISK_COOLDOWN) && !reached(now_q, cool_dl_q);
    danger_inc = (danger_run_q != achc_pkg::RunMax) ? danger_run_q + 1'b1 : danger_run_q;
    clear_inc  = (clear_run_q != achc_pkg::RunMax) ? clear_run_q + 1'b1 : clear_run_q;
    hold_sum   = 32'(now_q) + 32'(hold_ticks_q);
    cool_sum   = 32'(now_q) + 32'(cool_ticks_q);

    running_d    = running_q;
    risk_d       = risk_q;
    danger_run_d = danger_run_q;
    clear_run_d  = clear_run_q;
    hold_dl_d    = hold_dl_q;
    cool_dl_d    = cool_dl_q;
    overlay_d    = overlay_q;
    stable_d     = stable_q;
    detected_d   = detected_q;
    alert_conf_d = alert_conf_q;
    win_conf_d   = win_conf_q;
    alert_cnt_d  = alert_cnt_q;
    raised_d     = 1'b0;
    cleared_d    = 1'b0;

    case (cmd_q)
      achc_pkg::CMD_WINDOW: begin
        if (running_q) begin
          win_conf_d = prob_q;
          if (danger) begin
            danger_run_d = danger_inc;
            clear_run_d  = '0;
            hold_dl_d    = hold_sum[TW-1:0];
          end else begin
            danger_run_d = '0;
            clear_run_d  = clear_inc;
          end

          if (in_cool) begin
            risk_d = achc_pkg::RISK_COOLDOWN;
          end else if (danger && 32'(danger_run_d) >= 32'(confirm_q) && !overlay_q) begin
            risk_d       = achc_pkg::RISK_ALERTING;
            stable_d     = 1'b1;
            detected_d   = 1'b1;
            alert_conf_d = prob_q;
            alert_cnt_d  = alert_cnt_q + 32'd1;
            overlay_d    = 1'b1;
            raised_d     = 1'b1;
          end else if (danger && overlay_q) begin
            // Another danger window while alarmed refreshes the confidence.
            risk_d       = achc_pkg::RISK_ALERTING;
            stable_d     = 1'b1;
            alert_conf_d = prob_q;
          end else if (danger) begin
            risk_d = achc_pkg::RISK_SUSPICIOUS;
          end else if (overlay_q) begin
            if (reached(now_q, hold_dl_q) && 32'(clear_run_d) >= 32'(clear_cnt_q)) begin
              stable_d  = 1'b0;
              overlay_d = 1'b0;
              cool_dl_d = cool_sum[TW-1:0];
              risk_d    = achc_pkg::RISK_COOLDOWN;
              cleared_d = 1'b1;
            end else begin
              risk_d = achc_pkg::RISK_ALERTING;
            end
          end else if (risk_q == achc_pkg::RISK_COOLDOWN) begin
            risk_d = reached(now_q, cool_dl_q) ? achc_pkg::RISK_MONITORING
                                               : achc_pkg::RISK_COOLDOWN;
          end else begin
            risk_d = achc_pkg::RISK_MONITORING;
          end
        end
      end
      achc_pkg::CMD_START, achc_pkg::CMD_STOP: begin
        // Start while already running leaves everything as it is.
        if (cmd_q == achc_pkg::CMD_STOP || !running_q) begin
          running_d    = (cmd_q == achc_pkg::CMD_START);
          risk_d       = (cmd_q == achc_pkg::CMD_START) ? achc_pkg::RISK_MONITORING
                                                        : achc_pkg::RISK_OFF;
          danger_run_d = '0;
          clear_run_d  = '0;
          hold_dl_d    = '0;
          cool_dl_d    = '0;
          overlay_d    = 1'b0;
          stable_d     = 1'b0;
          detected_d   = 1'b0;
          alert_conf_d = '0;
          win_conf_d   = '0;
          alert_cnt_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      risk_q       <= achc_pkg::RISK_OFF;
      danger_run_q <= '0;
      clear_run_q  <= '0;
      hold_dl_q    <= '0;
      cool_dl_q    <= '0;
      overlay_q    <= 1'b0;
      stable_q     <= 1'b0;
      detected_q   <= 1'b0;
      alert_conf_q <= '0;
      win_conf_q   <= '0;
      alert_cnt_q  <= '0;
    end else if (advance) begin
      running_q    <= running_d;
      risk_q       <= risk_d;
      danger_run_q <= danger_run_d;
      clear_run_q  <= clear_run_d;
      hold_dl_q    <= hold_dl_d;
      cool_dl_q    <= cool_dl_d;
      overlay_q    <= overlay_d;
      stable_q     <= stable_d;
      detected_q   <= detected_d;
      alert_conf_q <= alert_conf_d;
      win_conf_q   <= win_conf_d;
      alert_cnt_q  <= alert_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_risk_q       <= risk_d;
      res_raised_q     <= raised_d;
      res_cleared_q    <= cleared_d;
      res_alert_num_q  <= alert_cnt_d;
      res_active_q     <= overlay_d;
      res_stable_q     <= stable_d;
      res_detected_q   <= detected_d;
      res_alert_conf_q <= alert_conf_d;
      res_win_conf_q   <= win_conf_d;
    end
  end

  assign out_if.valid                 = out_vld_q;
  assign out_if.risk_code             = res_risk_q;
  assign out_if.alert_raised          = res_raised_q;
  assign out_if.alert_cleared         = res_cleared_q;
  assign out_if.alert_number          = res_alert_num_q;
  assign out_if.alarm_active          = res_active_q;
  assign out_if.stable_danger         = res_stable_q;
  assign out_if.last_detected_danger  = res_detected_q;
  assign out_if.last_alert_confidence = res_alert_conf_q;
  assign out_if.latest_confidence     = res_win_conf_q;

endmodule

// ===== hdl/achc_chk.sv =====
// ----------------------------------------------------------------------------
// Alarm qualifier checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module achc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  risk_code_i,
  input logic        alert_raised_i,
  input logic        alert_cleared_i,
  input logic [31:0] alert_number_i,
  input logic        alarm_active_i
);

  // A stalled result transaction keeps its alert number.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(alert_number_i))
    else $error("stalled result changed");

  // A raise always shows the alarm on and the risk state alerting.
  a_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alert_raised_i |->
      alarm_active_i && risk_code_i == achc_pkg::RISK_ALERTING && !alert_cleared_i)
    else $error("raise without alerting state");

  // A clear always shows the alarm off and the risk state in cooldown.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alert_cleared_i |->
      !alarm_active_i && risk_code_i == achc_pkg::RISK_COOLDOWN)
    else $error("clear without cooldown state");

  // The alarm is never active while the block is off.
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && risk_code_i == achc_pkg::RISK_OFF |-> !alarm_active_i)
    else $error("alarm active while off");

endmodule

bind alarm_confirm_hold_cooldown_core achc_chk u_achc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .risk_code_i    (out_if.risk_code),
  .alert_raised_i (out_if.alert_raised),
  .alert_cleared_i(out_if.alert_cleared),
  .alert_number_i (out_if.alert_number),
  .alarm_active_i (out_if.alarm_active)
);

// ===== sim/alarm_confirm_hold_cooldown_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm qualifier core testbench
// Drives command and window transactions through the valid/ready channels
// and checks every result against a cycle-free model of the alarm
// qualification, or against the fixed expected result of a pinned script
// row. A short scripted sequence comes first, then constrained random
// episodes under several register settings, with bursty input and a
// stalling result receiver.
module alarm_confirm_hold_cooldown_core_tb;

  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned ItemsPerPhase  = 320;
  localparam int unsigned PhaseCount     = 6;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned ReportLimit    = 10;
  localparam logic [1:0]  CmdIgnored     = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  class_label;
    logic [15:0] prob;
    logic [31:0] tick_stamp;
  } window_t;

  typedef struct packed {
    logic [2:0]  risk;
    logic        raised;
    logic        cleared;
    logic [31:0] number;
    logic        active;
    logic        stable;
    logic        detected;
    logic [15:0] alert_conf;
    logic [15:0] latest_conf;
  } verdict_t;

  typedef struct packed {
    window_t  item;
    logic     pinned;
    verdict_t verdict;
  } script_row_t;

  localparam verdict_t OffVerdict =
    '{achc_pkg::RISK_OFF, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0};
  localparam verdict_t MonitoringVerdict =
    '{achc_pkg::RISK_MONITORING, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0};

  logic clk_i;
  logic rst_ni;

  logic                              cfg_we;
  achc_pkg::cfg_idx_e                cfg_idx;
  logic [achc_pkg::CfgDataWidth-1:0] cfg_wdata;

  logic     send_valid;
  window_t  send_item;
  logic     send_pin;
  verdict_t send_verdict;
  logic     take_ready;

  achc_in_if  window_ch ();
  achc_out_if verdict_ch ();

  assign window_ch.valid              = send_valid;
  assign window_ch.command            = send_item.command;
  assign window_ch.class_label        = send_item.class_label;
  assign window_ch.danger_probability = send_item.prob;
  assign window_ch.tick_stamp         = send_item.tick_stamp;
  assign verdict_ch.ready             = take_ready;

  alarm_confirm_hold_cooldown_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (window_ch),
    .out_if      (verdict_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Register copies.
  logic [7:0]  confirm_need;
  logic [7:0]  clear_need;
  logic [30:0] hold_span;
  logic [30:0] quiet_span;

  // Qualifier state.
  logic                           armed;
  achc_pkg::risk_e                risk_now;
  logic [achc_pkg::RunWidth-1:0]  danger_streak;
  logic [achc_pkg::RunWidth-1:0]  calm_streak;
  logic [achc_pkg::TickWidth-1:0] hold_until;
  logic [achc_pkg::TickWidth-1:0] quiet_until;
  logic                           overlay;
  logic                           stable_danger_f;
  logic                           seen_danger;
  logic [15:0]                    raise_conf;
  logic [15:0]                    last_conf;
  logic [31:0]                    alerts_raised;

  verdict_t    pending_verdicts[$];
  script_row_t script_q[$];
  int unsigned windows_taken;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned stall_cycles;

  // Random stimulus bookkeeping.
  logic        plan_danger;
  int unsigned plan_left;
  logic [31:0] tick_now;
  int unsigned burst_left;

  function automatic void clear_state();
    armed           = 1'b0;
    risk_now        = achc_pkg::RISK_OFF;
    danger_streak   = '0;
    calm_streak     = '0;
    hold_until      = '0;
    quiet_until     = '0;
    overlay         = 1'b0;
    stable_danger_f = 1'b0;
    seen_danger     = 1'b0;
    raise_conf      = '0;
    last_conf       = '0;
    alerts_raised   = '0;
  endfunction

  // A deadline counts as reached when the wrapped difference is not negative.
  function automatic logic tick_reached(logic [achc_pkg::TickWidth-1:0] now,
                                        logic [achc_pkg::TickWidth-1:0] deadline);
    logic [achc_pkg::TickWidth-1:0] diff;
    diff = now - deadline;
    return !diff[achc_pkg::TickWidth-1];
  endfunction

  function automatic verdict_t qualify_window(window_t w);
    verdict_t                       v;
    logic                           danger;
    logic                           in_quiet;
    logic [achc_pkg::TickWidth-1:0] now;
    achc_pkg::risk_e                nxt;
    v      = '0;
    now    = w.tick_stamp[achc_pkg::TickWidth-1:0];
    danger = (w.class_label == achc_pkg::DangerLabel);
    case (w.command)
      achc_pkg::CMD_WINDOW: begin
        if (armed) begin
          in_quiet  = (risk_now == achc_pkg::RISK_COOLDOWN) && !tick_reached(now, quiet_until);
          last_conf = w.prob;
          if (danger) begin
            if (danger_streak != achc_pkg::RunMax) danger_streak++;
            calm_streak = '0;
            hold_until  = now + 32'(hold_span);
          end else begin
            danger_streak = '0;
            if (calm_streak != achc_pkg::RunMax) calm_streak++;
          end
          if (in_quiet) begin
            nxt = achc_pkg::RISK_COOLDOWN;
          end else if (danger && danger_streak >= confirm_need && !overlay) begin
            nxt             = achc_pkg::RISK_ALERTING;
            stable_danger_f = 1'b1;
            seen_danger     = 1'b1;
            raise_conf      = w.prob;
            alerts_raised   = alerts_raised + 32'd1;
            overlay         = 1'b1;
            v.raised        = 1'b1;
          end else if (danger && overlay) begin
            nxt             = achc_pkg::RISK_ALERTING;
            stable_danger_f = 1'b1;
            raise_conf      = w.prob;
          end else if (danger) begin
            nxt = achc_pkg::RISK_SUSPICIOUS;
          end else if (overlay) begin
            if (tick_reached(now, hold_until) && calm_streak >= clear_need) begin
              stable_danger_f = 1'b0;
              overlay         = 1'b0;
              quiet_until     = now + 32'(quiet_span);
              nxt             = achc_pkg::RISK_COOLDOWN;
              v.cleared       = 1'b1;
            end else begin
              nxt = achc_pkg::RISK_ALERTING;
            end
          end else if (risk_now == achc_pkg::RISK_COOLDOWN) begin
            if (tick_reached(now, quiet_until)) nxt = achc_pkg::RISK_MONITORING;
            else nxt = achc_pkg::RISK_COOLDOWN;
          end else begin
            nxt = achc_pkg::RISK_MONITORING;
          end
          risk_now = nxt;
        end
      end
      achc_pkg::CMD_START: begin
        if (!armed) begin
          clear_state();
          armed    = 1'b1;
          risk_now = achc_pkg::RISK_MONITORING;
        end
      end
      achc_pkg::CMD_STOP: begin
        clear_state();
      end
      default: ;
    endcase
    v.risk        = risk_now;
    v.number      = alerts_raised;
    v.active      = overlay;
    v.stable      = stable_danger_f;
    v.detected    = seen_danger;
    v.alert_conf  = raise_conf;
    v.latest_conf = last_conf;
    return v;
  endfunction

  function automatic string describe(verdict_t v);
    return {$sformatf("risk=%0d raised=%0b cleared=%0b number=%0d active=%0b",
                      v.risk, v.raised, v.cleared, v.number, v.active),
            $sformatf(" stable=%0b detected=%0b alert_conf=%h latest=%h",
                      v.stable, v.detected, v.alert_conf, v.latest_conf)};
  endfunction

  // Run length around the threshold in half of the cases, so that raises and
  // clears happen often; now and then a run long enough to saturate.
  function automatic int unsigned run_length(logic [7:0] need);
    int unsigned n;
    if ($urandom_range(0, 199) == 0) return $urandom_range(256, 300);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = need + $urandom_range(0, 2);
      4:          n = (need > 1) ? need - 1 : 1;
      default:    n = $urandom_range(1, 6);
    endcase
    return (n == 0) ? 1 : n;
  endfunction

  function automatic window_t next_window();
    window_t     w;
    int unsigned pick;
    int unsigned stop_odds;
    pick          = $urandom_range(0, 999);
    w.class_label = 8'($urandom);
    w.prob        = 16'($urandom);
    // Long thresholds need long unbroken runs, so stops get rarer there.
    stop_odds = (confirm_need > 16 || clear_need > 16) ? 1 : 20;
    if (!armed && pick < 500) begin
      w.command = achc_pkg::CMD_START;
    end else if (pick < 20) begin
      w.command = achc_pkg::CMD_START;
    end else if (pick < 20 + stop_odds) begin
      w.command = achc_pkg::CMD_STOP;
    end else if (pick < 30 + stop_odds) begin
      w.command = CmdIgnored;
    end else begin
      w.command = achc_pkg::CMD_WINDOW;
      if (plan_left == 0) begin
        plan_danger = !plan_danger;
        plan_left   = run_length(plan_danger ? confirm_need : clear_need);
      end
      plan_left--;
      if (plan_danger && $urandom_range(0, 19) != 0) begin
        w.class_label = achc_pkg::DangerLabel;
      end else if (!plan_danger) begin
        while (w.class_label == achc_pkg::DangerLabel) w.class_label = 8'($urandom);
      end
    end
    case ($urandom_range(0, 19))
      0:       tick_now = $urandom;
      1, 2:    tick_now = hold_until + 32'($urandom_range(0, 2)) - 32'd1;
      3, 4:    tick_now = quiet_until + 32'($urandom_range(0, 2)) - 32'd1;
      5:       tick_now = tick_now + 32'(hold_span);
      6:       tick_now = tick_now + 32'(quiet_span);
      default: tick_now = tick_now + 32'($urandom_range(0, 24));
    endcase
    w.tick_stamp = tick_now;
    return w;
  endfunction

  task automatic add_row(logic [1:0] cmd, logic [7:0] label, logic [15:0] prob,
                         logic [31:0] now, logic pin, verdict_t v);
    script_row_t r;
    r.item    = '{cmd, label, prob, now};
    r.pinned  = pin;
    r.verdict = v;
    script_q.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_window(window_t it, logic pin, verdict_t v);
    int unsigned target;
    target = windows_taken + 1;
    send_item    <= it;
    send_pin     <= pin;
    send_verdict <= v;
    send_valid   <= 1'b1;
    do @(negedge clk_i); while (windows_taken != target);
  endtask

  task automatic pace();
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(0, 40);
      if ($urandom_range(0, 3) != 0) begin
        send_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  endtask

  task automatic settle();
    send_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(achc_pkg::cfg_idx_e idx, logic [achc_pkg::CfgDataWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    case (idx)
      achc_pkg::CFG_CONFIRM_COUNT:  confirm_need = data[7:0];
      achc_pkg::CFG_CLEAR_COUNT:    clear_need   = data[7:0];
      achc_pkg::CFG_HOLD_TICKS:     hold_span    = data;
      achc_pkg::CFG_COOLDOWN_TICKS: quiet_span   = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [achc_pkg::CfgDataWidth-1:0] confirm,
                               logic [achc_pkg::CfgDataWidth-1:0] calm,
                               logic [achc_pkg::CfgDataWidth-1:0] hold,
                               logic [achc_pkg::CfgDataWidth-1:0] quiet);
    write_reg(achc_pkg::CFG_CONFIRM_COUNT, confirm);
    write_reg(achc_pkg::CFG_CLEAR_COUNT, calm);
    write_reg(achc_pkg::CFG_HOLD_TICKS, hold);
    write_reg(achc_pkg::CFG_COOLDOWN_TICKS, quiet);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result receiver: switches between stall patterns, each kept for a random stretch.
  initial begin : sink_pacing
    int unsigned mode;
    int unsigned left;
    take_ready = 1'b0;
    mode       = 0;
    left       = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 200);
      end
      left--;
      case (mode)
        0:       take_ready <= 1'b1;
        1:       take_ready <= ($urandom_range(0, 3) != 0);
        2:       take_ready <= ($urandom_range(0, 1) != 0);
        default: take_ready <= (left % 5 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : scoreboard
    verdict_t predicted;
    verdict_t got;
    verdict_t want;
    logic     moved;
    moved = 1'b0;
    if (window_ch.valid && window_ch.ready) begin
      predicted = qualify_window(send_item);
      pending_verdicts.push_back(send_pin ? send_verdict : predicted);
      windows_taken++;
      moved = 1'b1;
    end
    if (verdict_ch.valid && verdict_ch.ready) begin
      got = '{verdict_ch.risk_code, verdict_ch.alert_raised, verdict_ch.alert_cleared,
              verdict_ch.alert_number, verdict_ch.alarm_active, verdict_ch.stable_danger,
              verdict_ch.last_detected_danger, verdict_ch.last_alert_confidence,
              verdict_ch.latest_confidence};
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result %0d arrived with nothing expected: %s", results_seen, describe(got));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.risk !== want.risk || got.raised !== want.raised ||
            got.cleared !== want.cleared || got.number !== want.number ||
            got.active !== want.active || got.stable !== want.stable ||
            got.detected !== want.detected || got.alert_conf !== want.alert_conf ||
            got.latest_conf !== want.latest_conf) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
      results_seen++;
      moved = 1'b1;
    end
    if (rst_ni) begin
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_verdicts.size());
        $display("alarm_confirm_hold_cooldown_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned produced;
    window_t     w;
    send_valid    = 1'b0;
    send_item     = '0;
    send_pin      = 1'b0;
    send_verdict  = '0;
    cfg_we        = 1'b0;
    cfg_idx       = achc_pkg::CFG_CONFIRM_COUNT;
    cfg_wdata     = '0;
    windows_taken = 0;
    results_seen  = 0;
    mismatches    = 0;
    stall_cycles  = 0;
    plan_danger   = 1'b0;
    plan_left     = 0;
    burst_left    = 0;
    tick_now      = $urandom;
    confirm_need  = achc_pkg::ConfirmCountRst;
    clear_need    = achc_pkg::ClearCountRst;
    hold_span     = achc_pkg::HoldTicksRst;
    quiet_span    = achc_pkg::CooldownTicksRst;
    clear_state();

    // Scripted episode at the reset settings: ignored items, a raise, refresh,
    // clear after the hold, cooldown suppression, and deadlines across the wrap.
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'hFFFF, 32'd0,         1'b1, OffVerdict);
    add_row(CmdIgnored,           8'd0,   16'h0000, 32'd0,         1'b1, OffVerdict);
    add_row(achc_pkg::CMD_STOP,   8'd0,   16'h0000, 32'd0,         1'b1, OffVerdict);
    add_row(achc_pkg::CMD_START,  8'd0,   16'h0000, 32'd0,         1'b1, MonitoringVerdict);
    add_row(achc_pkg::CMD_START,  8'd1,   16'hFFFF, 32'd5,         1'b1, MonitoringVerdict);
    add_row(achc_pkg::CMD_WINDOW, 8'd0,   16'h1234, 32'd10,        1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'hFFFF, 32'd20,        1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'h8000, 32'd30,        1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'h0000, 32'd40,        1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd0,   16'h0001, 32'd2100,      1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd255, 16'h00FF, 32'd2200,      1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd2,   16'hFF00, 32'd2300,      1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'h7FFF, 32'd2400,      1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'h8001, 32'd2500,      1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd0,   16'h5555, 32'd5300,      1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'hAAAA, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'hC3C3, 32'd5,         1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd0,   16'h3C3C, 32'h0000_0100, 1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd0,   16'h0F0F, 32'd2004,      1'b0, '0);
    add_row(achc_pkg::CMD_WINDOW, 8'd0,   16'hF0F0, 32'd2005,      1'b0, '0);
    add_row(achc_pkg::CMD_STOP,   8'd0,   16'h0000, 32'd2006,      1'b1, OffVerdict);
    add_row(achc_pkg::CMD_WINDOW, 8'd1,   16'hFFFF, 32'd2007,      1'b1, OffVerdict);
    add_row(achc_pkg::CMD_START,  8'd0,   16'h0000, 32'd2008,      1'b1, MonitoringVerdict);

    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script_q[i]) begin
      push_window(script_q[i].item, script_q[i].pinned, script_q[i].verdict);
      pace();
    end

    for (phase = 0; phase < PhaseCount; phase++) begin
      settle();
      case (phase)
        1: load_settings(31'd1, 31'd1, 31'd0, 31'd0);
        2: load_settings(31'd0, 31'd0, 31'd5, 31'd7);
        3: load_settings(31'd255, 31'd255, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        4: load_settings({23'($urandom), 8'($urandom_range(1, 6))},
                         {23'($urandom), 8'($urandom_range(1, 6))},
                         31'($urandom_range(0, 3000)), 31'($urandom_range(0, 3000)));
        5: load_settings({23'($urandom), 8'($urandom_range(0, 4))},
                         {23'($urandom), 8'($urandom_range(0, 4))},
                         31'($urandom), 31'($urandom));
        default: ;
      endcase
      produced = 0;
      while (produced < ItemsPerPhase) begin
        w = next_window();
        // Windows while stopped do not count toward the phase length.
        if (w.command != achc_pkg::CMD_WINDOW || armed) produced++;
        push_window(w, 1'b0, '0);
        pace();
      end
    end

    send_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("alarm_confirm_hold_cooldown_core_tb OK");
    end else begin
      $display("alarm_confirm_hold_cooldown_core_tb NOT OK");
    end
    $finish;
  end

endmodule
